// File: rtl/cbt_pkg.sv
// Shared types, constants and helpers for the color blob centroid tracker.
// No dependencies.
package cbt_pkg;

   localparam int SUM_W  = 30;
   localparam int AREA_W = 21;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 16;

   localparam logic [7:0] HUE_LO = 8'd7;
   localparam logic [7:0] HUE_HI = 8'd17;
   localparam logic [7:0] SAT_LO = 8'd120;
   localparam logic [7:0] VAL_LO = 8'd150;

   localparam logic [CSR_AW-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_AW-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_AW-1:0] REG_DEAD_BAND    = 3'd2;
   localparam logic [CSR_AW-1:0] REG_GAIN_P_FWD   = 3'd3;
   localparam logic [CSR_AW-1:0] REG_GAIN_D_FWD   = 3'd4;
   localparam logic [CSR_AW-1:0] REG_GAIN_P_LAT   = 3'd5;
   localparam logic [CSR_AW-1:0] REG_GAIN_D_LAT   = 3'd6;
   localparam logic [CSR_AW-1:0] REG_MIN_INTERVAL = 3'd7;

   typedef struct packed {
      logic [7:0]  hue;
      logic [7:0]  saturation;
      logic [7:0]  brightness;
      logic        end_of_frame;
      logic [31:0] frame_time_ms;
   } pixel_type;

   typedef struct packed {
      logic signed [15:0] vel_forward;
      logic signed [15:0] vel_lateral;
      logic [13:0]        centroid_col;
      logic [13:0]        centroid_row;
      logic               target_found;
      logic               command_updated;
   } result_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_COL_GO, ST_COL_WAIT, ST_ROW_GO, ST_ROW_WAIT, ST_CHECK,
      ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
      ST_DIV_GO, ST_DIV_WAIT, ST_OUT
   } state_type;

   function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
      logic signed [15:0] r;
      if (v > 20'sd32767) r = 16'sh7FFF;
      else if (v < -20'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

endpackage

// File: rtl/color_blob_centroid_pd_tracker_core.sv
// Color blob centroid tracker with PD velocity command.
// Pixels: one per cycle while idle, each accumulated in the cycle it is accepted.
// End of frame: uses the shared 1-bit-per-cycle divider (two centroid divides
// plus one per command) and 8 steps on the shared multiplier.
// Reset (synchronous, active high) restores defaults, clears FSM, sums and history.
module color_blob_centroid_pd_tracker_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  cbt_pkg::pixel_type        req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output cbt_pkg::result_type       rsp_data,
   input  logic                      csr_wr_en,
   input  logic [cbt_pkg::CSR_AW-1:0] csr_index,
   input  logic [cbt_pkg::CSR_DW-1:0] csr_wdata
);
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WSW = $clog2(MAX_WIDTH + 1);
   localparam int HSW = $clog2(MAX_HEIGHT + 1);

   // configuration
   logic [10:0]        frame_width_ff, frame_height_ff;
   logic [7:0]         dead_band_ff;
   logic signed [15:0] kp_fwd_ff, kd_fwd_ff, kp_lat_ff, kd_lat_ff;
   logic [15:0]        min_interval_ff;

   cbt_pkg::state_type state_ff, state_in;

   logic [CW-1:0]              col_ff, col_in;
   logic [RW-1:0]              row_ff, row_in;
   logic [cbt_pkg::SUM_W-1:0]  col_sum_ff, col_sum_in, row_sum_ff, row_sum_in;
   logic [cbt_pkg::AREA_W-1:0] area_ff, area_in;
   logic [31:0]                now_ff, now_in, last_ff, last_in, dte_ff, dte_in;
   logic [13:0]                ccol_ff, ccol_in, crow_ff, crow_in;
   logic                       found_ff, found_in, upd_ff, upd_in, lat_ff, lat_in;
   logic signed [15:0]         ef_ff, ef_in, el_ff, el_in;
   logic signed [15:0]         efp_ff, efp_in, elp_ff, elp_in;
   logic signed [15:0]         cmdf_ff, cmdf_in, cmdl_ff, cmdl_in, newf_ff, newf_in;
   logic signed [31:0]         t1_ff, t1_in;
   logic signed [63:0]         acc_ff, acc_in;
   logic [47:0]                den_ff, den_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   cbt_pkg::result_type        rsp_data_ff, rsp_data_in;

   logic [WSW-1:0] w_eff;
   logic [HSW-1:0] h_eff;

   logic signed [32:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [50:0] mul_p;

   logic        div_start, div_done;
   logic [63:0] div_dividend;
   logic [47:0] div_divisor;
   logic [3:0]  div_qbits;
   logic [15:0] div_quot;

   logic               hit;
   logic [31:0]        dt;
   logic signed [19:0] ef_full, el_full;
   logic signed [15:0] e_cur, ep_cur, kp_cur, kd_cur, cmd_val;
   logic signed [16:0] de_cur;
   logic [16:0]        e_mag;
   logic               in_band, acc_neg;
   logic [17:0]        size_cur;
   logic [63:0]        acc_mag;

   cbt_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p(mul_p));

   cbt_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .qbits(div_qbits), .done(div_done), .quot(div_quot)
   );

   always_comb begin
      if (frame_width_ff == 11'd0) w_eff = WSW'(1);
      else if (32'(frame_width_ff) > MAX_WIDTH) w_eff = WSW'(MAX_WIDTH);
      else w_eff = WSW'(frame_width_ff);
      if (frame_height_ff == 11'd0) h_eff = HSW'(1);
      else if (32'(frame_height_ff) > MAX_HEIGHT) h_eff = HSW'(MAX_HEIGHT);
      else h_eff = HSW'(frame_height_ff);
   end

   assign hit = (req_data.hue >= cbt_pkg::HUE_LO) && (req_data.hue <= cbt_pkg::HUE_HI) &&
                (req_data.saturation >= cbt_pkg::SAT_LO) &&
                (req_data.brightness >= cbt_pkg::VAL_LO);

   assign dt      = now_ff - last_ff;
   assign ef_full = signed'(20'(h_eff >> 1) << 4) - signed'(20'(crow_ff));
   assign el_full = signed'(20'(w_eff >> 1) << 4) - signed'(20'(ccol_ff));

   assign e_cur    = lat_ff ? el_ff : ef_ff;
   assign ep_cur   = lat_ff ? elp_ff : efp_ff;
   assign kp_cur   = lat_ff ? kp_lat_ff : kp_fwd_ff;
   assign kd_cur   = lat_ff ? kd_lat_ff : kd_fwd_ff;
   assign size_cur = lat_ff ? 18'(w_eff) : 18'(h_eff);
   assign de_cur   = 17'(e_cur) - 17'(ep_cur);
   assign e_mag    = e_cur[15] ? -17'(e_cur) : 17'(e_cur);
   assign in_band  = e_mag < {5'd0, dead_band_ff, 4'd0};
   assign acc_neg  = acc_ff[63];
   assign acc_mag  = acc_neg ? 64'(-acc_ff) : 64'(acc_ff);

   always_comb begin
      if (in_band) cmd_val = '0;
      else if (div_quot[15]) cmd_val = acc_neg ? 16'sh8000 : 16'sh7FFF;
      else if (acc_neg) cmd_val = -signed'({1'b0, div_quot[14:0]});
      else cmd_val = signed'({1'b0, div_quot[14:0]});
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      col_sum_in   = col_sum_ff;
      row_sum_in   = row_sum_ff;
      area_in      = area_ff;
      now_in       = now_ff;
      last_in      = last_ff;
      dte_in       = dte_ff;
      ccol_in      = ccol_ff;
      crow_in      = crow_ff;
      found_in     = found_ff;
      upd_in       = upd_ff;
      lat_in       = lat_ff;
      ef_in        = ef_ff;
      el_in        = el_ff;
      efp_in       = efp_ff;
      elp_in       = elp_ff;
      cmdf_in      = cmdf_ff;
      cmdl_in      = cmdl_ff;
      newf_in      = newf_ff;
      t1_in        = t1_ff;
      acc_in       = acc_ff;
      den_in       = den_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dividend = 64'({col_sum_ff, 4'd0});
      div_divisor  = 48'(area_ff);
      div_qbits    = 4'd14;

      unique case (state_ff)
         cbt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (hit) begin
                  col_sum_in = col_sum_ff + cbt_pkg::SUM_W'(col_ff);
                  row_sum_in = row_sum_ff + cbt_pkg::SUM_W'(row_ff);
                  area_in    = area_ff + 1'b1;
               end
               if (req_data.end_of_frame) begin
                  now_in   = req_data.frame_time_ms;
                  upd_in   = 1'b0;
                  state_in = cbt_pkg::ST_COL_GO;
               end else if ((32'(col_ff) + 32'd1) >= 32'(w_eff)) begin
                  col_in = '0;
                  row_in = ((32'(row_ff) + 32'd1) >= 32'(h_eff)) ? '0 : row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         cbt_pkg::ST_COL_GO: begin
            found_in = area_ff != '0;
            if (area_ff == '0) begin
               ccol_in  = '0;
               crow_in  = '0;
               state_in = cbt_pkg::ST_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = cbt_pkg::ST_COL_WAIT;
            end
         end
         cbt_pkg::ST_COL_WAIT: begin
            if (div_done) begin
               ccol_in  = div_quot[14] ? 14'h3FFF : div_quot[13:0];
               state_in = cbt_pkg::ST_ROW_GO;
            end
         end
         cbt_pkg::ST_ROW_GO: begin
            div_dividend = 64'({row_sum_ff, 4'd0});
            div_start    = 1'b1;
            state_in     = cbt_pkg::ST_ROW_WAIT;
         end
         cbt_pkg::ST_ROW_WAIT: begin
            if (div_done) begin
               crow_in  = div_quot[14] ? 14'h3FFF : div_quot[13:0];
               state_in = cbt_pkg::ST_CHECK;
            end
         end
         cbt_pkg::ST_CHECK: begin
            if (dt < 32'(min_interval_ff)) begin
               state_in = cbt_pkg::ST_OUT;
            end else begin
               ef_in    = cbt_pkg::sat16(ef_full);
               el_in    = cbt_pkg::sat16(el_full);
               dte_in   = (dt == 32'd0) ? 32'd1 : dt;
               lat_in   = 1'b0;
               state_in = cbt_pkg::ST_M1;
            end
         end
         // kp*e*dt + kd*(e - e_prev)*1000, and size*dt, in partial products
         cbt_pkg::ST_M1: begin
            mul_a    = 33'(kp_cur);
            mul_b    = 18'(e_cur);
            state_in = cbt_pkg::ST_M2;
         end
         cbt_pkg::ST_M2: begin
            t1_in    = signed'(mul_p[31:0]);
            mul_a    = 33'(signed'(mul_p[31:0]));
            mul_b    = signed'({2'b0, dte_ff[15:0]});
            state_in = cbt_pkg::ST_M3;
         end
         cbt_pkg::ST_M3: begin
            acc_in   = 64'(mul_p);
            mul_a    = 33'(t1_ff);
            mul_b    = signed'({2'b0, dte_ff[31:16]});
            state_in = cbt_pkg::ST_M4;
         end
         cbt_pkg::ST_M4: begin
            acc_in   = acc_ff + (64'(mul_p) <<< 16);
            mul_a    = 33'(kd_cur);
            mul_b    = 18'(de_cur);
            state_in = cbt_pkg::ST_M5;
         end
         cbt_pkg::ST_M5: begin
            mul_a    = signed'(mul_p[32:0]);
            mul_b    = 18'sd1000;
            state_in = cbt_pkg::ST_M6;
         end
         cbt_pkg::ST_M6: begin
            acc_in   = acc_ff + 64'(mul_p);
            mul_a    = signed'(33'(size_cur));
            mul_b    = signed'({2'b0, dte_ff[15:0]});
            state_in = cbt_pkg::ST_M7;
         end
         cbt_pkg::ST_M7: begin
            den_in   = 48'(mul_p);
            mul_a    = signed'(33'(size_cur));
            mul_b    = signed'({2'b0, dte_ff[31:16]});
            state_in = cbt_pkg::ST_M8;
         end
         cbt_pkg::ST_M8: begin
            den_in   = den_ff + (48'(mul_p) << 16);
            state_in = cbt_pkg::ST_DIV_GO;
         end
         cbt_pkg::ST_DIV_GO: begin
            div_dividend = acc_mag;
            div_divisor  = {den_ff[44:0], 3'd0};
            div_qbits    = 4'd15;
            div_start    = 1'b1;
            state_in     = cbt_pkg::ST_DIV_WAIT;
         end
         cbt_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               if (!lat_ff) begin
                  newf_in  = cmd_val;
                  lat_in   = 1'b1;
                  state_in = cbt_pkg::ST_M1;
               end else begin
                  cmdf_in  = newf_ff;
                  cmdl_in  = cmd_val;
                  efp_in   = ef_ff;
                  elp_in   = el_ff;
                  last_in  = now_ff;
                  upd_in   = 1'b1;
                  state_in = cbt_pkg::ST_OUT;
               end
            end
         end
         cbt_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.vel_forward     = cmdf_ff;
               rsp_data_in.vel_lateral     = cmdl_ff;
               rsp_data_in.centroid_col    = ccol_ff;
               rsp_data_in.centroid_row    = crow_ff;
               rsp_data_in.target_found    = found_ff;
               rsp_data_in.command_updated = upd_ff;
               rsp_valid_in = 1'b1;
               col_in       = '0;
               row_in       = '0;
               col_sum_in   = '0;
               row_sum_in   = '0;
               area_in      = '0;
               state_in     = cbt_pkg::ST_IDLE;
            end
         end
         default: state_in = cbt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= cbt_pkg::ST_IDLE;
         frame_width_ff  <= 11'd640;
         frame_height_ff <= 11'd480;
         dead_band_ff    <= 8'd10;
         kp_fwd_ff       <= 16'sd2048;
         kd_fwd_ff       <= -16'sd20;
         kp_lat_ff       <= 16'sd4506;
         kd_lat_ff       <= -16'sd41;
         min_interval_ff <= 16'd333;
         col_ff          <= '0;
         row_ff          <= '0;
         col_sum_ff      <= '0;
         row_sum_ff      <= '0;
         area_ff         <= '0;
         efp_ff          <= '0;
         elp_ff          <= '0;
         last_ff         <= '0;
         cmdf_ff         <= '0;
         cmdl_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         upd_ff          <= 1'b0;
         found_ff        <= 1'b0;
         lat_ff          <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         col_sum_ff   <= col_sum_in;
         row_sum_ff   <= row_sum_in;
         area_ff      <= area_in;
         efp_ff       <= efp_in;
         elp_ff       <= elp_in;
         last_ff      <= last_in;
         cmdf_ff      <= cmdf_in;
         cmdl_ff      <= cmdl_in;
         rsp_valid_ff <= rsp_valid_in;
         upd_ff       <= upd_in;
         found_ff     <= found_in;
         lat_ff       <= lat_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               cbt_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[10:0];
               cbt_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata[10:0];
               cbt_pkg::REG_DEAD_BAND:    dead_band_ff    <= csr_wdata[7:0];
               cbt_pkg::REG_GAIN_P_FWD:   kp_fwd_ff       <= signed'(csr_wdata);
               cbt_pkg::REG_GAIN_D_FWD:   kd_fwd_ff       <= signed'(csr_wdata);
               cbt_pkg::REG_GAIN_P_LAT:   kp_lat_ff       <= signed'(csr_wdata);
               cbt_pkg::REG_GAIN_D_LAT:   kd_lat_ff       <= signed'(csr_wdata);
               cbt_pkg::REG_MIN_INTERVAL: min_interval_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      now_ff      <= now_in;
      dte_ff      <= dte_in;
      ccol_ff     <= ccol_in;
      crow_ff     <= crow_in;
      ef_ff       <= ef_in;
      el_ff       <= el_in;
      newf_ff     <= newf_in;
      t1_ff       <= t1_in;
      acc_ff      <= acc_in;
      den_ff      <= den_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// File: rtl/cbt_mul.sv
// Shared signed multiplier with registered product.
// Depends on nothing.
module cbt_mul (
   input  logic               clock,
   input  logic signed [32:0] a,
   input  logic signed [17:0] b,
   output logic signed [50:0] p
);
   logic signed [50:0] p_ff;
   logic signed [50:0] p_in;

   assign p_in = 51'(a) * 51'(b);

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;
endmodule

// File: rtl/cbt_div.sv
// Restoring divider, one quotient bit per cycle, MSB first.
// Produces quotient bits qbits..0; bit qbits set means overflow. Depends on nothing.
module cbt_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [47:0] divisor,
   input  logic [3:0]  qbits,
   output logic        done,
   output logic [15:0] quot
);
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dsh_ff, dsh_in;
   logic [15:0] q_ff, q_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsh_in  = 64'(divisor) << qbits;
         q_in    = '0;
         cnt_in  = qbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[14:0], 1'b1};
         end else begin
            q_in   = {q_ff[14:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
